// ===== rtl/fault_formation_heightmap_macros.svh =====
// Assertion macros for the checker file.
`ifndef FAULT_FORMATION_HEIGHTMAP_MACROS_SVH
`define FAULT_FORMATION_HEIGHTMAP_MACROS_SVH

// Check a property while the block is out of reset.
`define FFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define FFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ffh_pkg.sv =====
package ffh_pkg;

  // Grid geometry
  localparam int GRID_MAX = 64;
  localparam int COORD_W  = $clog2(GRID_MAX);
  localparam int SIDE_W   = COORD_W + 1;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int ADDR_W   = 2 * COORD_W;

  // Arithmetic widths
  localparam int H_W     = 40;
  localparam int FD_W    = 16;
  localparam int RAISE_W = 10;
  localparam int STR_W   = 16;
  localparam int NUM_W   = H_W + 8;
  localparam int Q_W     = RAISE_W;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RAISE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAISE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EROSION     = 3'd4;

  localparam logic [SIDE_W-1:0]  RST_GRID_SIDE   = SIDE_W'(GRID_MAX);
  localparam logic [FD_W-1:0]    RST_FAULT_COUNT = 16'd64;
  localparam logic [RAISE_W-1:0] RST_MIN_RAISE   = 10'd0;
  localparam logic [RAISE_W-1:0] RST_MAX_RAISE   = 10'd32;
  localparam logic [STR_W-1:0]   RST_EROSION     = 16'd0;

  // Item modes and result status codes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_FAULT  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_EQUAL     = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COORD_W-1:0] x_a;
    logic [COORD_W-1:0] z_a;
    logic [COORD_W-1:0] x_b;
    logic [COORD_W-1:0] z_b;
  } in_t;

  typedef struct packed {
    logic [7:0] height;
    logic [1:0] status;
  } out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_RAISE_DIV = 4'd2,
    OP_RAISE_SET = 4'd3,
    OP_RAISE     = 4'd4,
    OP_LOADV     = 4'd5,
    OP_DIFF      = 4'd6,
    OP_MUL       = 4'd7,
    OP_ERODE     = 4'd8,
    OP_MM_FIRST  = 4'd9,
    OP_MM        = 4'd10,
    OP_READ_DIV  = 4'd11
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               rd;
    logic               fault_end;
    logic [ADDR_W-1:0]  addr;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cz;
  } cmd_t;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              exhausted;
    logic              div_done;
    logic              quick;
    logic [7:0]        quick_val;
    logic [7:0]        quot;
  } stat_t;

endpackage

// ===== rtl/ffh_ram.sv =====
module ffh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ffh_div.sv =====
module ffh_div import ffh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [H_W-1:0]   den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int DSH_W = H_W + Q_W - 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic             fits;

  // Quotient is known to stay below 2^Q_W: one bit per cycle
  assign fits = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(Q_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring step: subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {den, {(Q_W-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - NUM_W'(dsh);
      end
      quot <= {quot[Q_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

// ===== rtl/ffh_dp.sv =====
module ffh_dp import ffh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_t                  in_data,
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int MAG_W  = H_W + 1;
  localparam int HI_W   = MAG_W - STR_W;
  localparam int PHI_W  = HI_W + STR_W;
  localparam int PLO_W  = 2 * STR_W;
  localparam int ADD_W  = RAISE_W + 8;
  localparam int LINE_W = COORD_W + 2;
  localparam int TEST_W = 2 * LINE_W + 1;
  localparam int SUM_W  = H_W + 2;

  // Configuration registers
  logic [SIDE_W-1:0]  grid_side;
  logic [FD_W-1:0]    fault_count;
  logic [RAISE_W-1:0] min_raise;
  logic [RAISE_W-1:0] max_raise;
  logic [STR_W-1:0]   strength;

  // Grid state
  logic [FD_W-1:0]      faults_done;
  logic signed [H_W-1:0] lowest;
  logic signed [H_W-1:0] highest;

  // Working registers
  logic [COORD_W-1:0]    xa, za, xb, zb;
  logic [ADD_W-1:0]      add;
  logic signed [H_W-1:0] v;
  logic signed [H_W-1:0] cur;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [PHI_W-1:0]      p_hi;
  logic [PLO_W-1:0]      p_lo;

  logic [H_W-1:0]        rdata;
  logic signed [H_W-1:0] h;
  logic                  we;
  logic [H_W-1:0]        wdata;

  logic [SIDE_W-1:0] side;
  logic              span_neg;
  logic [RAISE_W-1:0] span_mag;
  logic [NUM_W-1:0]  div_num;
  logic [H_W-1:0]    div_den;
  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    div_quot;
  logic [RAISE_W:0]  raise;

  logic signed [LINE_W-1:0] dx, dz, ex, ez;
  logic signed [TEST_W-1:0] side_test;
  logic                     above;
  logic signed [H_W:0]      raised;
  logic [H_W-1:0]           raised_sat;

  logic signed [H_W:0]   diff;
  logic [PLO_W:0]        lo_rnd;
  logic [SUM_W-1:0]      m;
  logic signed [SUM_W-1:0] eroded;

  logic              flat;
  logic              quick;
  logic [7:0]        quick_val;
  logic [H_W-1:0]    rd_off;
  logic [H_W-1:0]    rd_span;

  assign h = $signed(rdata);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side   <= RST_GRID_SIDE;
      fault_count <= RST_FAULT_COUNT;
      min_raise   <= RST_MIN_RAISE;
      max_raise   <= RST_MAX_RAISE;
      strength    <= RST_EROSION;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIDE:   grid_side   <= cfg_data[SIDE_W-1:0];
        REG_FAULT_COUNT: fault_count <= cfg_data[FD_W-1:0];
        REG_MIN_RAISE:   min_raise   <= cfg_data[RAISE_W-1:0];
        REG_MAX_RAISE:   max_raise   <= cfg_data[RAISE_W-1:0];
        REG_EROSION:     strength    <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the side in use
  always_comb begin
    priority if (grid_side < SIDE_W'(2)) begin
      side = SIDE_W'(2);
    end else if (grid_side > SIDE_W'(GRID_MAX)) begin
      side = SIDE_W'(GRID_MAX);
    end else begin
      side = grid_side;
    end
  end

  // Raise interpolation: |span| * faults_done / fault_count
  assign span_neg = max_raise < min_raise;
  assign span_mag = span_neg ? (min_raise - max_raise) : (max_raise - min_raise);
  assign raise    = span_neg ? ({1'b0, max_raise} + {1'b0, div_quot})
                             : ({1'b0, max_raise} - {1'b0, div_quot});

  // Line test for the current cell
  assign dx = $signed({2'b00, xb}) - $signed({2'b00, xa});
  assign dz = $signed({2'b00, zb}) - $signed({2'b00, za});
  assign ex = $signed({2'b00, cmd.cx}) - $signed({2'b00, xa});
  assign ez = $signed({2'b00, cmd.cz}) - $signed({2'b00, za});
  assign side_test = TEST_W'(ex * dz) - TEST_W'(dx * ez);
  assign above     = side_test > 0;

  // Raised height, saturated upwards
  assign raised = $signed({h[H_W-1], h}) + $signed({{(H_W+1-ADD_W){1'b0}}, add});
  assign raised_sat = (raised[H_W] != raised[H_W-1]) ? {1'b0, {(H_W-1){1'b1}}}
                                                     : raised[H_W-1:0];

  // Erosion: difference, then products, then rounded step
  assign diff   = $signed({v[H_W-1], v}) - $signed({h[H_W-1], h});
  assign lo_rnd = {1'b0, p_lo} + (PLO_W+1)'(32768);
  assign m      = SUM_W'(p_hi) + SUM_W'(lo_rnd[PLO_W:STR_W]);
  assign eroded = neg ? ($signed(SUM_W'(cur)) - $signed(m))
                      : ($signed(SUM_W'(cur)) + $signed(m));

  // Read normalisation: cases that need no division
  always_comb begin
    flat      = highest <= lowest;
    quick     = 1'b1;
    quick_val = 8'd0;
    priority if (flat) begin
      priority if (h < 0) begin
        quick_val = 8'd0;
      end else if (|h[H_W-2:16]) begin
        quick_val = 8'd255;
      end else begin
        quick_val = h[15:8];
      end
    end else if (h <= lowest) begin
      quick_val = 8'd0;
    end else if (h >= highest) begin
      quick_val = 8'd255;
    end else begin
      quick = 1'b0;
    end
  end

  assign rd_off  = h - lowest;
  assign rd_span = highest - lowest;

  // Shared divider: raise interpolation or read scaling
  assign div_start = (cmd.op == OP_RAISE_DIV) || (cmd.op == OP_READ_DIV);
  always_comb begin
    if (cmd.op == OP_READ_DIV) begin
      div_num = {rd_off, 8'd0} - NUM_W'(rd_off);
      div_den = rd_span;
    end else begin
      div_num = NUM_W'(span_mag * faults_done);
      div_den = H_W'(fault_count);
    end
  end

  ffh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Height memory writes
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1;
      end
      OP_RAISE: begin
        we    = above;
        wdata = raised_sat;
      end
      OP_ERODE: begin
        we    = 1'b1;
        wdata = eroded[H_W-1:0];
      end
      default: ;
    endcase
  end

  ffh_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cmd.addr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  // Grid state: fault counter and extremes
  always_ff @(posedge clk) begin
    if (rst) begin
      faults_done <= '0;
      lowest      <= '0;
      highest     <= '0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          faults_done <= '0;
          lowest      <= '0;
          highest     <= '0;
        end
        OP_MM_FIRST: begin
          lowest  <= h;
          highest <= h;
        end
        OP_MM: begin
          if (h > highest) begin
            highest <= h;
          end
          if (h < lowest) begin
            lowest <= h;
          end
        end
        default: ;
      endcase
      if (cmd.fault_end) begin
        faults_done <= faults_done + FD_W'(1);
      end
    end
  end

  // Working registers of the passes
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_RAISE_DIV: begin
        xa <= in_data.x_a;
        za <= in_data.z_a;
        xb <= in_data.x_b;
        zb <= in_data.z_b;
      end
      OP_RAISE_SET: add <= {raise[RAISE_W-1:0], 8'd0};
      OP_LOADV:     v   <= h;
      OP_DIFF: begin
        cur <= h;
        neg <= diff[H_W];
        mag <= diff[H_W] ? MAG_W'(-diff) : MAG_W'(diff);
      end
      OP_MUL: begin
        p_hi <= mag[MAG_W-1:STR_W] * strength;
        p_lo <= mag[STR_W-1:0] * strength;
      end
      OP_ERODE: v <= eroded[H_W-1:0];
      default: ;
    endcase
  end

  assign stat.side      = side;
  assign stat.exhausted = faults_done >= fault_count;
  assign stat.div_done  = div_done;
  assign stat.quick     = quick;
  assign stat.quick_val = quick_val;
  assign stat.quot      = div_quot[7:0];

endmodule

// ===== rtl/ffh_ctrl.sv =====
module ffh_ctrl import ffh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_DIV     = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_RD_EVAL = 6'b010000,
    ST_RD_DIV  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    P_RAISE = 3'd0,
    P_LR    = 3'd1,
    P_RL    = 3'd2,
    P_TB    = 3'd3,
    P_BT    = 3'd4,
    P_MM    = 3'd5
  } pass_t;

  state_t state, state_next;
  pass_t  pass, pass_next;
  logic [ADDR_W-1:0]  clr_cnt, clr_cnt_next;
  logic               clr_reply, clr_reply_next;
  logic [COORD_W-1:0] line, line_next;
  logic [COORD_W-1:0] pos, pos_next;
  logic [1:0]         ph, ph_next;
  logic               out_valid_next;
  out_t               out_data_next;

  logic               accept;
  logic [COORD_W-1:0] last_idx;
  logic [COORD_W-1:0] rev;
  logic [COORD_W-1:0] x, z;
  logic               short_cell;
  logic               cell_done;

  assign in_stall = (state != ST_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  // Scan geometry: map line and position to a cell for each pass
  assign last_idx = COORD_W'(stat.side - SIDE_W'(1));
  assign rev      = last_idx - pos;
  always_comb begin
    unique case (pass)
      P_RL: begin
        x = rev;
        z = line;
      end
      P_TB: begin
        x = line;
        z = pos;
      end
      P_BT: begin
        x = line;
        z = rev;
      end
      default: begin
        x = pos;
        z = line;
      end
    endcase
  end

  assign short_cell = (pass == P_RAISE) || (pass == P_MM) || (pos == '0);
  assign cell_done  = short_cell ? (ph == 2'd1) : (ph == 2'd3);

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    clr_cnt_next   = clr_cnt;
    clr_reply_next = clr_reply;
    line_next      = line;
    pos_next       = pos;
    ph_next        = ph;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    cmd            = '0;
    cmd.op         = OP_NOP;
    cmd.addr       = {z, x};
    cmd.cx         = x;
    cmd.cz         = z;

    unique case (state)
      // Sweep zeros through the whole memory
      ST_CLEAR: begin
        cmd.op       = OP_CLEAR;
        cmd.addr     = clr_cnt;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (&clr_cnt) begin
          state_next = ST_IDLE;
          if (clr_reply) begin
            out_valid_next       = 1'b1;
            out_data_next.height = 8'd0;
            out_data_next.status = STATUS_DONE;
          end
        end
      end

      // Decode an accepted transaction
      ST_IDLE: begin
        if (accept) begin
          out_data_next.height = 8'd0;
          out_data_next.status = STATUS_DONE;
          unique case (in_data.mode)
            MODE_CLEAR: begin
              state_next     = ST_CLEAR;
              clr_cnt_next   = '0;
              clr_reply_next = 1'b1;
            end
            MODE_FAULT: begin
              priority if (stat.exhausted) begin
                out_valid_next       = 1'b1;
                out_data_next.status = STATUS_EXHAUSTED;
              end else if (in_data.x_a == in_data.x_b && in_data.z_a == in_data.z_b) begin
                out_valid_next       = 1'b1;
                out_data_next.status = STATUS_EQUAL;
              end else begin
                cmd.op     = OP_RAISE_DIV;
                state_next = ST_DIV;
              end
            end
            MODE_READ: begin
              if ({1'b0, in_data.x_a} < stat.side && {1'b0, in_data.z_a} < stat.side) begin
                cmd.rd     = 1'b1;
                cmd.addr   = {in_data.z_a, in_data.x_a};
                state_next = ST_RD_EVAL;
              end else begin
                out_valid_next = 1'b1;
              end
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end

      // Wait for the raise interpolation
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.op     = OP_RAISE_SET;
          state_next = ST_SCAN;
          pass_next  = P_RAISE;
          line_next  = '0;
          pos_next   = '0;
          ph_next    = 2'd0;
        end
      end

      // Walk the grid: raise, four erosion sweeps, extremes
      ST_SCAN: begin
        if (ph == 2'd0) begin
          cmd.rd = 1'b1;
        end else begin
          unique case (pass)
            P_RAISE: cmd.op = OP_RAISE;
            P_MM:    cmd.op = (line == '0 && pos == '0) ? OP_MM_FIRST : OP_MM;
            default: begin
              if (pos == '0) begin
                cmd.op = OP_LOADV;
              end else begin
                unique case (ph)
                  2'd1:    cmd.op = OP_DIFF;
                  2'd2:    cmd.op = OP_MUL;
                  default: cmd.op = OP_ERODE;
                endcase
              end
            end
          endcase
        end
        ph_next = cell_done ? 2'd0 : (ph + 2'd1);
        if (cell_done) begin
          if (pos == last_idx) begin
            pos_next = '0;
            if (line == last_idx) begin
              line_next = '0;
              if (pass == P_MM) begin
                cmd.fault_end        = 1'b1;
                state_next           = ST_IDLE;
                out_valid_next       = 1'b1;
                out_data_next.height = 8'd0;
                out_data_next.status = STATUS_DONE;
              end else begin
                pass_next = pass_t'(pass + 3'd1);
              end
            end else begin
              line_next = line + COORD_W'(1);
            end
          end else begin
            pos_next = pos + COORD_W'(1);
          end
        end
      end

      // Read data is back: finish directly or scale
      ST_RD_EVAL: begin
        if (stat.quick) begin
          state_next           = ST_IDLE;
          out_valid_next       = 1'b1;
          out_data_next.height = stat.quick_val;
          out_data_next.status = STATUS_DONE;
        end else begin
          cmd.op     = OP_READ_DIV;
          state_next = ST_RD_DIV;
        end
      end

      ST_RD_DIV: begin
        if (stat.div_done) begin
          state_next           = ST_IDLE;
          out_valid_next       = 1'b1;
          out_data_next.height = stat.quot;
          out_data_next.status = STATUS_DONE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pass      <= P_RAISE;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      line      <= '0;
      pos       <= '0;
      ph        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      clr_cnt   <= clr_cnt_next;
      clr_reply <= clr_reply_next;
      line      <= line_next;
      pos       <= pos_next;
      ph        <= ph_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

// ===== rtl/fault_formation_heightmap.sv =====
// Fault-formation height map with erosion filter.
// Input channel (in_valid / in_stall / in_data) takes one transaction at a
// time: clear the grid, apply a fault between two points, or read one cell.
// Each transaction gives exactly one result on out_valid / out_stall /
// out_data, held in an output register until taken; a new input is taken
// only once that register is empty.
// Work per transaction:
//   clear: a zeroing sweep through every memory row.
//   fault: a raise walk over the grid, four erosion sweeps and an extremes
//          walk; a rejected fault is answered without any walk.
//   read : one memory read, then a division when the value needs scaling.
// The time is set by the height memory walk, one address per step: one read and one
// write per cell in raise, and a four-step read, subtract, multiply, write
// chain per cell in each erosion sweep, which depends on the cell before.
// Reset runs the same zeroing sweep; inputs stall meanwhile, but
// configuration writes (cfg_write / cfg_index / cfg_data) are taken at once.
// A stalled receiver holds the result and stalls the input side behind it.
module fault_formation_heightmap import ffh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  ffh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/ffh_check.sv =====
`include "fault_formation_heightmap_macros.svh"

module ffh_check import ffh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Hold a stalled result
  `FFH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // One transaction in flight: stall right after an accept
  `FFH_ASSERT(a_one_in_flight, in_valid && !in_stall |=> in_stall, "input taken while busy")

  // No input while a result waits
  `FFH_ASSERT(a_pending_stalls, out_valid |-> in_stall, "input open with result pending")

  // Only a result with done status carries a nonzero height
  `FFH_ASSERT(a_height_done, out_valid && out_data.height != 8'd0 |-> out_data.status == STATUS_DONE, "height on a rejected result")

  // Reset starts the zeroing sweep
  `FFH_ASSERT_ALWAYS(a_reset_sweep, rst |=> in_stall && !out_valid, "block open right after reset")

endmodule

bind fault_formation_heightmap ffh_check u_check (.*);
